### rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types, constants and helpers for the decimal text converter
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int MAG_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

    // handoff from the binary-to-bcd converter to the character emitter
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } sitda_conv_t;

    // add 3 to every bcd digit that is 5 or more, ahead of the next shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0]   res;
        logic [DIGIT_W-1:0] d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= ADJ_LIMIT)
            begin
                res[i*DIGIT_W +: DIGIT_W] = d + ADJ_ADD;
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / value) takes one signed 32-bit
//   integer per beat. output channel (out_valid / out_stall / ascii_char /
//   last) returns its decimal text, most significant character first: an
//   optional '-', then the digits with leading zeros dropped; last marks
//   the final character. zero gives a single '0'.
// flow:
//   the magnitude goes through a double-dabble converter one bit a cycle
//   and is handed to the emitter, which drops up to 9 leading zeros,
//   one a cycle, and then sends its 1 to 11 characters one a cycle
//   while the receiver does not stall. the converter takes the next
//   value once its result has moved to the emitter; only receiver
//   stalls that keep the emitter busy until the converter is done
//   stretch the gap between values.
// reset: rst_n clears both sequencers and the output valid; any run in
//   flight is dropped.
// stall: a stalled character holds in the output register; the emitter
//   waits, and once the converter holds a finished result in_stall stays
//   high until the emitter is free.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sitda_pkg::MAG_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sitda_pkg::CHAR_W-1:0]  ascii_char,
    output logic                          last
);
    import sitda_pkg::*;

    // converter result waiting for the emitter
    sitda_conv_t conv;
    logic        conv_ready;

    // bit-serial magnitude to bcd
    sitda_dabble u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .conv       (conv),
        .conv_ready (conv_ready)
    );

    // leading-zero skip and character output register
    sitda_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv       (conv),
        .conv_ready (conv_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    // converter is busy in the cycle after taking a value
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("converter took a value without going busy");

    // only the sign or a decimal digit ever leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ascii_char == CHAR_MINUS ||
                       (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 8'd9)))
        else $error("character is neither sign nor digit");

    // the sign never ends a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ascii_char == CHAR_MINUS) |-> !last)
        else $error("sign marked as last character");

    // a taken sign beat is never followed by a second sign beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && ascii_char == CHAR_MINUS) |=>
            !(out_valid && ascii_char == CHAR_MINUS))
        else $error("two sign characters in a row");

endmodule

### rtl/core/sitda_dabble.sv
// ----------------------------------------------------------------------------
// sitda_dabble
// bit-serial binary to bcd converter, one magnitude bit per cycle
// ----------------------------------------------------------------------------
module sitda_dabble (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sitda_pkg::MAG_W-1:0]  value,
    output sitda_pkg::sitda_conv_t       conv,
    input  logic                         conv_ready
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        CV_IDLE = 3'b001,
        CV_RUN  = 3'b010,
        CV_HOLD = 3'b100
    } cv_state_t;

    cv_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [BCD_W-1:0]   bcd_adj;

    assign in_stall   = (state_reg != CV_IDLE);
    assign bcd_adj    = bcd_adjust(bcd_reg);
    assign conv.valid = (state_reg == CV_HOLD);
    assign conv.neg   = neg_reg;
    assign conv.bcd   = bcd_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[MAG_W-1];
                    mag_next   = value[MAG_W-1] ? (MAG_W'(0) - value) : value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = CV_RUN;
                end
            end
            CV_RUN:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
                mag_next  = {mag_reg[MAG_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = CV_HOLD;
                end
            end
            CV_HOLD:
            begin
                if (conv_ready)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

### rtl/core/sitda_emit.sv
// ----------------------------------------------------------------------------
// sitda_emit
// character emitter: skips leading zeros, then sends sign and digits
// ----------------------------------------------------------------------------
module sitda_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sitda_pkg::sitda_conv_t        conv,
    output logic                          conv_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sitda_pkg::CHAR_W-1:0]  ascii_char,
    output logic                          last
);
    import sitda_pkg::*;

    typedef enum logic [2:0] {
        EM_IDLE = 3'b001,
        EM_SKIP = 3'b010,
        EM_EMIT = 3'b100
    } em_state_t;

    em_state_t           state_reg, state_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                sign_reg, sign_next;
    logic                oval_reg, oval_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic [DIGIT_W-1:0]  top_digit;
    logic                out_free;

    assign top_digit  = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign out_free   = !oval_reg || !out_stall;
    assign conv_ready = (state_reg == EM_IDLE);
    assign out_valid  = oval_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        rem_next   = rem_reg;
        sign_next  = sign_reg;
        oval_next  = out_free ? 1'b0 : oval_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (conv.valid)
                begin
                    bcd_next   = conv.bcd;
                    sign_next  = conv.neg;
                    rem_next   = REM_W'(NUM_DIGITS);
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP:
            begin
                // drop one leading zero a cycle, always keep the final digit
                if (top_digit == '0 && rem_reg != REM_W'(1))
                begin
                    bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = EM_EMIT;
                end
            end
            EM_EMIT:
            begin
                if (out_free)
                begin
                    oval_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + CHAR_W'(top_digit);
                        last_next = (rem_reg == REM_W'(1));
                        bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        rem_next  = rem_reg - 1'b1;
                        if (rem_reg == REM_W'(1))
                        begin
                            state_next = EM_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            oval_reg  <= 1'b0;
            rem_reg   <= '0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
            rem_reg   <= rem_next;
            sign_reg  <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### tb/signed_int_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// self-checking bench for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
// each integer beat taken by the block is turned into its decimal text by a
// local predictor, and every character beat that leaves the block is checked
// in order against that text. directed values cover zero, the extremes and
// some digit count boundaries; random values are spread over every digit
// count and the full 32-bit range, under several idle and stall mixes and a
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sitda_pkg::*;

    localparam int SETTLE_CYCLES = 80;     // above the longest run the block needs
    localparam int HOLD_CYCLES   = 400;    // long enough for two values to pile up
    localparam int MAX_REPORTS   = 10;

    // one expected character beat
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } char_beat_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [MAG_W-1:0]    value;
    logic                out_valid;
    logic                out_stall;
    logic [CHAR_W-1:0]   ascii_char;
    logic                last;

    // decimal text still owed by the block, oldest character first
    char_beat_t pending_text[$];

    int mismatch_count;
    int send_idle_pct;
    int stall_pct;
    int hold_left;

    signed_int_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor: append the decimal text of one value to the pending text
    // ------------------------------------------------------------------------
    function automatic void push_decimal_text(input logic [MAG_W-1:0] v);
        logic [MAG_W-1:0]   mag;
        logic [DIGIT_W-1:0] digs[NUM_DIGITS];
        int                 nd;
        char_beat_t         beat;
        // magnitude as unsigned, so the most negative value needs no care
        mag = v[MAG_W-1] ? (32'd0 - v) : v;
        nd  = 0;
        do
        begin
            digs[nd] = DIGIT_W'(mag % 10);
            mag      = mag / 10;
            nd++;
        end
        while (mag != 0 && nd < NUM_DIGITS);
        if (v[MAG_W-1])
        begin
            beat.ch      = CHAR_MINUS;
            beat.is_last = 1'b0;
            pending_text.push_back(beat);
        end
        // most significant digit first, zero itself gives one '0'
        for (int k = nd - 1; k >= 0; k--)
        begin
            beat.ch      = CHAR_ZERO + CHAR_W'(digs[k]);
            beat.is_last = (k == 0);
            pending_text.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender: one integer beat, with a random idle gap in front of it
    // ------------------------------------------------------------------------
    task automatic send_value(input logic [MAG_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        // the beat is taken at the first edge where stall is low
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        push_decimal_text(v);
    endtask

    // sender pauses until every owed character has come out
    task automatic wait_text_drained();
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random value with a chosen digit count, either sign
    function automatic logic [MAG_W-1:0] value_with_digits(input int n);
        longint lo;
        longint hi;
        logic [MAG_W-1:0] mag;
        lo = 1;
        for (int i = 1; i < n; i++)
        begin
            lo = lo * 10;
        end
        hi = (n == NUM_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
        if (n == 1)
        begin
            lo = 0;
        end
        mag = $urandom_range(32'(hi), 32'(lo));
        return $urandom_range(1) ? (32'd0 - mag) : mag;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checker: every character beat against the oldest owed character
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_text.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected beat char %h last %b",
                             $realtime, ascii_char, last);
                end
            end
            else
            begin
                want = pending_text.pop_front();
                if (ascii_char !== want.ch || last !== want.is_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                                 $realtime, want.ch, want.is_last, ascii_char, last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero, the extremes and several boundaries of the digit count
    task automatic test_directed_values();
        logic [MAG_W-1:0] vals[$];
        vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd100, 32'd999, 32'd1000, 32'd99999, -32'sd100000,
                 32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
                 32'h5555_5555, 32'hAAAA_AAAA};
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (vals[i])
        begin
            send_value(vals[i]);
        end
        wait_text_drained();
    endtask

    // random values: mostly by digit count, the rest from the whole range
    task automatic test_random_values(input int n, input int idle_pct, input int st_pct);
        send_idle_pct = idle_pct;
        stall_pct     = st_pct;
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_value($urandom());
            end
            else
            begin
                send_value(value_with_digits($urandom_range(NUM_DIGITS, 1)));
            end
        end
        wait_text_drained();
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        repeat (8)
        begin
            send_value(value_with_digits($urandom_range(NUM_DIGITS, 1)));
        end
        wait_text_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values(95, 0, 0);
        test_random_values(95, 47, 0);
        test_random_values(95, 0, 47);
        test_random_values(95, 34, 34);
        test_output_holdoff();

        if (mismatch_count == 0 && pending_text.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/sitda_pkg.sv
rtl/core/sitda_dabble.sv
rtl/core/sitda_emit.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
